@@ rtl/imh_pkg.sv @@
package imh_pkg;

    localparam int IdW = 8;
    localparam int KeyW = 64;
    localparam int PayW = 32;
    localparam int OccW = 9;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELMIN = 2'd1;
    localparam logic [1:0] CMD_SETKEY = 2'd2;
    localparam logic [1:0] CMD_REMOVE = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_PRESENT   = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    typedef struct packed {
        logic [IdW-1:0]         id;
        logic signed [KeyW-1:0] key;
        logic [PayW-1:0]        payload;
    } slot_t;

    typedef struct packed {
        logic [1:0]             cmd;
        logic [PayW-1:0]        payload;
        logic signed [KeyW-1:0] key;
        logic [IdW-1:0]         item_id;
    } request_t;

    function automatic logic key_less(input logic signed [KeyW-1:0] a,
                                      input logic signed [KeyW-1:0] b);
        return a < b;
    endfunction

endpackage

@@ rtl/imh_slot_ram.sv @@
module imh_slot_ram #(
    parameter int DEPTH = 257,
    parameter int AW = 9
) (
    input  logic            aclk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  imh_pkg::slot_t  wdata,
    input  logic [AW-1:0]   raddr,
    output imh_pkg::slot_t  rdata
);
    import imh_pkg::*;

    slot_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/imh_pos_ram.sv @@
module imh_pos_ram #(
    parameter int DEPTH = 256,
    parameter int AW = 8,
    parameter int DW = 9
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);
    import imh_pkg::*;

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/indexed_min_heap.sv @@
// channel   | ports               | tuser          | tdata (lowest bit up)
// command   | s_tvalid / s_tready | cmd [1:0]      | item_id, key, payload (104 bits)
// result    | m_tvalid / m_tready | status [2:0]   | out_id, out_key, out_payload, occupancy
//
// one command at a time; the heap slots and the id position table sit in
// synchronous rams with one write port and one read port each
// insert climbs with a parent read and a compare per level; delete-min descends,
// remove climbs or descends (two child reads and a compare per level descended)
// after reset every entry of the position table is swept clear
// before the first command transaction is taken
// a finished result waits in the output register; a stalled result holds
// the next command at its last cycle
module indexed_min_heap #(
    parameter int CAPACITY = 256,
    parameter int ID_COUNT = 256
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [1:0]   s_tuser,   // cmd
    input  logic [103:0] s_tdata,   // item_id, key, payload
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [2:0]   m_tuser,   // status
    output logic [119:0] m_tdata    // out_id, out_key, out_payload, occupancy
);
    import imh_pkg::*;

    localparam int PW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(ID_COUNT);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DISP, S_ROOT, S_SEL, S_LAST,
        S_UP, S_UPCMP, S_DOWN, S_DL, S_DR, S_DCMP, S_FIN
    } state_t;

    state_t state_reg, state_next;
    logic [IW-1:0] clr_reg, clr_next;
    logic [PW-1:0] count_reg, count_next;
    logic          mval_reg, mval_next;
    logic [1:0]    cmd_reg, cmd_next;
    logic [IW-1:0] id_reg, id_next;
    logic signed [KeyW-1:0] key_reg, key_next;
    logic [PayW-1:0] pl_reg, pl_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [PW-1:0] caddr_reg, caddr_next;
    slot_t carry_reg, carry_next;
    slot_t child_reg, child_next;
    logic [2:0]    st_reg, st_next;
    logic [IdW-1:0] oid_reg, oid_next;
    logic signed [KeyW-1:0] okey_reg, okey_next;
    logic [PayW-1:0] opl_reg, opl_next;
    logic [OccW-1:0] occ_reg, occ_next;
    logic [2:0]    mst_reg, mst_next;
    logic [IdW-1:0] mid_reg, mid_next;
    logic signed [KeyW-1:0] mkey_reg, mkey_next;
    logic [PayW-1:0] mpl_reg, mpl_next;

    request_t req;
    logic [IW-1:0] in_id;

    logic          s_we;
    logic [PW-1:0] s_waddr, s_raddr;
    slot_t         s_wdata, s_rdata;
    logic          p_we;
    logic [IW-1:0] p_waddr, p_raddr;
    logic [PW-1:0] p_wdata, p_rdata;

    logic [PW:0]   two_pos;

    assign req = {s_tuser, s_tdata};
    assign in_id = IW'(32'(req.item_id) % ID_COUNT);
    assign two_pos = {pos_reg, 1'b0};

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mval_reg;
    assign m_tuser = mst_reg;
    assign m_tdata = {7'd0, occ_reg, mpl_reg, mkey_reg, mid_reg};

    imh_slot_ram #(.DEPTH(CAPACITY + 1), .AW(PW)) u_slots (
        .aclk(aclk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(s_raddr), .rdata(s_rdata)
    );

    imh_pos_ram #(.DEPTH(ID_COUNT), .AW(IW), .DW(PW)) u_pos (
        .aclk(aclk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(p_raddr), .rdata(p_rdata)
    );

    always_comb begin
        state_next = state_reg;
        clr_next = clr_reg;
        count_next = count_reg;
        mval_next = mval_reg && !m_tready;
        cmd_next = cmd_reg;
        id_next = id_reg;
        key_next = key_reg;
        pl_next = pl_reg;
        pos_next = pos_reg;
        caddr_next = caddr_reg;
        carry_next = carry_reg;
        child_next = child_reg;
        st_next = st_reg;
        oid_next = oid_reg;
        okey_next = okey_reg;
        opl_next = opl_reg;
        occ_next = occ_reg;
        mst_next = mst_reg;
        mid_next = mid_reg;
        mkey_next = mkey_reg;
        mpl_next = mpl_reg;
        s_we = 1'b0;
        s_waddr = pos_reg;
        s_wdata = carry_reg;
        s_raddr = pos_reg;
        p_we = 1'b0;
        p_waddr = IW'(carry_reg.id);
        p_wdata = pos_reg;
        p_raddr = in_id;

        unique case (state_reg)
            S_CLEAR: begin
                p_we = 1'b1;
                p_waddr = clr_reg;
                p_wdata = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == IW'(ID_COUNT - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd_next = req.cmd;
                    id_next = in_id;
                    key_next = req.key;
                    pl_next = req.payload;
                    st_next = ST_OK;
                    oid_next = '0;
                    okey_next = '0;
                    opl_next = '0;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                case (cmd_reg)
                    CMD_INSERT: begin
                        if (count_reg >= PW'(CAPACITY)) begin
                            st_next = ST_FULL;
                            state_next = S_FIN;
                        end else if (p_rdata != '0) begin
                            st_next = ST_PRESENT;
                            state_next = S_FIN;
                        end else begin
                            count_next = count_reg + 1'b1;
                            pos_next = count_reg + 1'b1;
                            carry_next = '{id: IdW'(id_reg), key: key_reg, payload: pl_reg};
                            state_next = S_UP;
                        end
                    end
                    CMD_DELMIN: begin
                        if (count_reg == '0) begin
                            st_next = ST_EMPTY;
                            state_next = S_FIN;
                        end else begin
                            s_raddr = PW'(1);
                            state_next = S_ROOT;
                        end
                    end
                    default: begin
                        if (p_rdata == '0 || p_rdata > count_reg) begin
                            st_next = ST_NOT_FOUND;
                            state_next = S_FIN;
                        end else begin
                            pos_next = p_rdata;
                            s_raddr = p_rdata;
                            state_next = S_SEL;
                        end
                    end
                endcase
            end
            S_ROOT: begin
                oid_next = s_rdata.id;
                okey_next = s_rdata.key;
                opl_next = s_rdata.payload;
                p_we = 1'b1;
                p_waddr = IW'(s_rdata.id);
                p_wdata = '0;
                count_next = count_reg - 1'b1;
                pos_next = PW'(1);
                s_raddr = count_reg;
                state_next = (count_reg == PW'(1)) ? S_FIN : S_LAST;
            end
            S_SEL: begin
                if (cmd_reg == CMD_SETKEY) begin
                    carry_next = '{id: s_rdata.id, key: key_reg, payload: s_rdata.payload};
                    state_next = key_less(key_reg, s_rdata.key) ? S_UP : S_DOWN;
                end else begin
                    oid_next = IdW'(id_reg);
                    okey_next = s_rdata.key;
                    opl_next = s_rdata.payload;
                    p_we = 1'b1;
                    p_waddr = id_reg;
                    p_wdata = '0;
                    count_next = count_reg - 1'b1;
                    s_raddr = count_reg;
                    state_next = (pos_reg == count_reg) ? S_FIN : S_LAST;
                end
            end
            S_LAST: begin
                carry_next = s_rdata;
                if (cmd_reg == CMD_REMOVE && key_less(s_rdata.key, okey_reg)) begin
                    state_next = S_UP;
                end else begin
                    state_next = S_DOWN;
                end
            end
            S_UP: begin
                if (pos_reg > PW'(1)) begin
                    s_raddr = pos_reg >> 1;
                    state_next = S_UPCMP;
                end else begin
                    s_we = 1'b1;
                    p_we = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_UPCMP: begin
                s_we = 1'b1;
                p_we = 1'b1;
                if (key_less(carry_reg.key, s_rdata.key)) begin
                    s_wdata = s_rdata;
                    p_waddr = IW'(s_rdata.id);
                    pos_next = pos_reg >> 1;
                    state_next = S_UP;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_DOWN: begin
                if (two_pos <= {1'b0, count_reg}) begin
                    s_raddr = PW'(two_pos);
                    state_next = S_DL;
                end else begin
                    s_we = 1'b1;
                    p_we = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_DL: begin
                child_next = s_rdata;
                caddr_next = PW'(two_pos);
                if (two_pos < {1'b0, count_reg}) begin
                    s_raddr = PW'(two_pos) + 1'b1;
                    state_next = S_DR;
                end else begin
                    state_next = S_DCMP;
                end
            end
            S_DR: begin
                if (key_less(s_rdata.key, child_reg.key)) begin
                    child_next = s_rdata;
                    caddr_next = caddr_reg + 1'b1;
                end
                state_next = S_DCMP;
            end
            S_DCMP: begin
                s_we = 1'b1;
                p_we = 1'b1;
                if (key_less(child_reg.key, carry_reg.key)) begin
                    s_wdata = child_reg;
                    p_waddr = IW'(child_reg.id);
                    pos_next = caddr_reg;
                    state_next = S_DOWN;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (!mval_reg || m_tready) begin
                    mval_next = 1'b1;
                    mst_next = st_reg;
                    occ_next = OccW'(count_reg);
                    mid_next = oid_reg;
                    mkey_next = okey_reg;
                    mpl_next = opl_reg;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
        id_reg <= id_next;
        key_reg <= key_next;
        pl_reg <= pl_next;
        pos_reg <= pos_next;
        caddr_reg <= caddr_next;
        carry_reg <= carry_next;
        child_reg <= child_next;
        st_reg <= st_next;
        oid_reg <= oid_next;
        okey_reg <= okey_next;
        opl_reg <= opl_next;
        occ_reg <= occ_next;
        mst_reg <= mst_next;
        mid_reg <= mid_next;
        mkey_reg <= mkey_next;
        mpl_reg <= mpl_next;
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            count_reg <= '0;
            mval_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            count_reg <= count_next;
            mval_reg <= mval_next;
        end
    end

endmodule
